/* src/stable_descending_score_sorter_macros.svh */
`ifndef STABLE_DESCENDING_SCORE_SORTER_MACROS_SVH
`define STABLE_DESCENDING_SCORE_SORTER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SDS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define SDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/sds_pkg.sv */
`default_nettype none

package sds_pkg;

    localparam int TagWidth   = 16;
    localparam int ScoreWidth = 32;

    typedef struct packed {
        logic                         valid;
        logic signed [ScoreWidth-1:0] score;
        logic [TagWidth-1:0]          tag;
    } slot_t;

    typedef struct packed {
        logic insert;
        logic drain;
    } ctrl_t;

endpackage

`default_nettype wire

/* src/sds_cell.sv */
`default_nettype none

module sds_cell (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire sds_pkg::ctrl_t                        ctrl,
    input  wire logic signed [sds_pkg::ScoreWidth-1:0] new_score,
    input  wire logic [sds_pkg::TagWidth-1:0]          new_tag,
    input  wire sds_pkg::slot_t                        prev_slot,
    input  wire logic                                  prev_disp,
    input  wire sds_pkg::slot_t                        next_slot,
    output sds_pkg::slot_t                             slot,
    output logic                                       disp
);

    logic                                  valid_reg;
    logic                                  valid_next;
    logic signed [sds_pkg::ScoreWidth-1:0] score_reg;
    logic signed [sds_pkg::ScoreWidth-1:0] score_next;
    logic [sds_pkg::TagWidth-1:0]          tag_reg;
    logic [sds_pkg::TagWidth-1:0]          tag_next;

    // Strict compare: an equal score stays ahead of the new pair
    assign disp = !valid_reg || (score_reg < new_score);

    always_comb
    begin
        valid_next = valid_reg;
        score_next = score_reg;
        tag_next   = tag_reg;
        if (ctrl.drain)
        begin
            // advance towards the head of the chain
            valid_next = next_slot.valid;
            score_next = next_slot.score;
            tag_next   = next_slot.tag;
        end
        else if (ctrl.insert && disp)
        begin
            if (prev_disp)
            begin
                valid_next = prev_slot.valid;
                score_next = prev_slot.score;
                tag_next   = prev_slot.tag;
            end
            else
            begin
                valid_next = 1'b1;
                score_next = new_score;
                tag_next   = new_tag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
        tag_reg   <= tag_next;
    end

    assign slot.valid = valid_reg;
    assign slot.score = score_reg;
    assign slot.tag   = tag_reg;

endmodule

`default_nettype wire

/* src/stable_descending_score_sorter.sv */
// Channel   | Handshake          | Payload
// ----------+--------------------+-----------------------------------------
// input     | start && !busy     | tag, score, is_last
// result    | strobe             | out_tag, out_score, out_last, overflowed
//
// While idle a pair is taken in every cycle; all cells compare and shift at once.
// After a pair with is_last, busy stays high while the chain, holding 1 to CAPACITY
// pairs, drains one result a cycle from its head, up to and including its final result.
// The first result appears in the cycle after the is_last transaction.
// Reset clears all cell valid bits, the drain flag and the overflow flag.
// The receiver cannot stall: every result is taken in its strobe cycle.
`default_nettype none

`include "stable_descending_score_sorter_macros.svh"

module stable_descending_score_sorter #(
    parameter int CAPACITY = 64
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [sds_pkg::TagWidth-1:0]          tag,
    input  wire logic signed [sds_pkg::ScoreWidth-1:0] score,
    input  wire logic                                  is_last,
    output logic                                       strobe,
    output logic [sds_pkg::TagWidth-1:0]               out_tag,
    output logic signed [sds_pkg::ScoreWidth-1:0]      out_score,
    output logic                                       out_last,
    output logic                                       overflowed
);

    sds_pkg::slot_t slots [CAPACITY];
    logic           disp  [CAPACITY];
    sds_pkg::ctrl_t ctrl;
    sds_pkg::slot_t empty_slot;

    logic drain_reg;
    logic drain_next;
    logic dropped_reg;
    logic dropped_next;
    logic accept;
    logic full;

    assign empty_slot = '0;
    assign accept     = start && !drain_reg;
    assign full       = slots[CAPACITY-1].valid;
    assign ctrl.insert = accept;
    assign ctrl.drain  = drain_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            sds_pkg::slot_t prev_slot;
            logic           prev_disp;
            sds_pkg::slot_t next_slot;

            if (gi == 0)
            begin : g_head
                assign prev_slot = empty_slot;
                assign prev_disp = 1'b0;
            end
            else
            begin : g_body
                assign prev_slot = slots[gi-1];
                assign prev_disp = disp[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign next_slot = empty_slot;
            end
            else
            begin : g_inner
                assign next_slot = slots[gi+1];
            end

            sds_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .new_score (score),
                .new_tag   (tag),
                .prev_slot (prev_slot),
                .prev_disp (prev_disp),
                .next_slot (next_slot),
                .slot      (slots[gi]),
                .disp      (disp[gi])
            );
        end
    endgenerate

    assign strobe     = drain_reg && slots[0].valid;
    assign out_tag    = slots[0].tag;
    assign out_score  = slots[0].score;
    assign out_last   = strobe && !slots[1].valid;
    assign overflowed = dropped_reg;
    assign busy       = drain_reg;

    always_comb
    begin
        drain_next   = drain_reg;
        dropped_next = dropped_reg;
        if (accept)
        begin
            if (is_last)
            begin
                drain_next = 1'b1;
            end
            // a full chain loses one pair, either the new one or the tail
            if (full)
            begin
                dropped_next = 1'b1;
            end
        end
        else if (out_last)
        begin
            drain_next   = 1'b0;
            dropped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg   <= 1'b0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            drain_reg   <= drain_next;
            dropped_reg <= dropped_next;
        end
    end

    `SDS_ASSERT_NEXT(a_last_starts_output, clk, rst_n, accept && is_last, strobe,
        "no result after the closing transaction")
    `SDS_ASSERT_NEXT(a_output_continues, clk, rst_n, strobe && !out_last, strobe,
        "result stream broke off before its final result")
    `SDS_ASSERT_NEXT(a_output_ends, clk, rst_n, out_last, !busy && !slots[0].valid,
        "chain not empty after the final result")
    `SDS_ASSERT_NEXT(a_overflow_marked, clk, rst_n, accept && full, overflowed,
        "overflow not recorded when the chain was full")
    `SDS_ASSERT_NOW(a_busy_has_data, clk, rst_n, busy, slots[0].valid,
        "draining with an empty chain head")

endmodule

`default_nettype wire
